// File: design/vertex_normal_accumulate_assert.svh
// assertion macros for the vertex normal accumulator
`ifndef VERTEX_NORMAL_ACCUMULATE_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATE_ASSERT_SVH
`ifndef SYNTHESIS
`define VNA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vna assertion failed");
`define VNA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vna assertion failed");
`else
`define VNA_ASSERT_IMP(label, ante, cons)
`define VNA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: design/vna_pkg.sv
// types and constants shared by the vertex normal accumulator
`default_nettype none
package vna_pkg;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int SUM_W            = 40;
  localparam int THR_W            = 40;
  localparam logic [THR_W-1:0] THR_RESET = 40'd1;
  localparam logic [14:0] NORM_ONE = 15'd16384;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRI   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [9:0]         index_a;
    logic [9:0]         index_b;
    logic [9:0]         index_c;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               status;
  } result_t;
endpackage
`default_nettype wire

// File: design/vna_ram.sv
// generic single write port ram with registered read
`default_nettype none
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/vertex_normal_accumulate.sv
// Area-weighted vertex normal accumulator. Positions and normal sums live in two
// MAX_VERTICES-deep rams with registered reads; one transaction is worked at a time.
// A load writes the position and clears the sum of an in-range index; a triangle does
// three position reads, a cross product, then three read-modify-writes on the sum ram;
// an out-of-range triangle or query, or a no-op, goes straight to the result. A query
// makes up to 30 single-bit normalising shifts, a 32-step square root and a 15-step divide.
// The next transaction is taken once the result is registered, while the result may
// still wait at the output.
`default_nettype none
`include "vertex_normal_accumulate_assert.svh"
module vertex_normal_accumulate #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = vna_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire vna_pkg::item_t             item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output vna_pkg::result_t                result,
  input  wire logic                       cfg_we,
  input  wire logic [vna_pkg::THR_W-1:0]  cfg_wdata
);
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = COORD_BITS;
  localparam int EW  = CW + 1;
  localparam int PRW = 2 * EW;
  localparam int FW  = PRW + 1;
  localparam int SW  = vna_pkg::SUM_W;
  localparam int XW  = ((FW > SW) ? FW : SW) + 1;
  localparam logic signed [XW-1:0] SMAX = XW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [XW-1:0] SMIN = ~SMAX;

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001, S_LOAD = 22'h000002, S_PA   = 22'h000004,
    S_PB    = 22'h000008, S_PC   = 22'h000010, S_PD   = 22'h000020,
    S_MUL   = 22'h000040, S_CROSS= 22'h000080, S_SRD  = 22'h000100,
    S_SWR   = 22'h000200, S_QRD  = 22'h000400, S_QMAG = 22'h000800,
    S_QSQ   = 22'h001000, S_QCHK = 22'h002000, S_NORM = 22'h004000,
    S_TSQ   = 22'h008000, S_TSUM = 22'h010000, S_ROOT = 22'h020000,
    S_DSET  = 22'h040000, S_DIV  = 22'h080000, S_OUT  = 22'h100000,
    S_FIN   = 22'h200000
  } state_t;

  state_t st;
  vna_pkg::item_t cur;
  vna_pkg::result_t pend;
  logic [vna_pkg::THR_W-1:0] thr;

  logic signed [CW-1:0]  pa [3];
  logic signed [CW-1:0]  pb [3];
  logic signed [CW-1:0]  pc [3];
  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [PRW-1:0] prod [6];
  logic signed [FW-1:0]  face [3];
  logic [1:0]            corner;
  logic [AW-1:0]         corner_addr;
  logic [AW-1:0]         addr_a, addr_b, addr_c;

  logic [SW-1:0]   t [3];
  logic [2:0]      neg;
  logic [SW-1:0]   mx;
  logic [41:0]     sqs;
  logic            mags_low, allzero;
  logic [61:0]     tsq [3];
  logic [63:0]     rad, res, rbit;
  logic [4:0]      rcnt;
  logic [31:0]     r_val;
  logic [31:0]     rem [3];
  logic [14:0]     nlow [3];
  logic [14:0]     q [3];
  logic [3:0]      dcnt;

  logic                 pos_we, sum_we;
  logic [AW-1:0]        pos_raddr, sum_raddr, sum_waddr;
  logic [3*CW-1:0]      pos_wdata, pos_rdata;
  logic [3*SW-1:0]      sum_wdata, sum_rdata, sat_word;
  logic signed [SW-1:0] sr [3];
  logic [63:0]          root_try;
  logic [31:0]          rr;
  logic [45:0]          nfull [3];
  logic [32:0]          dext [3];
  logic [SW-1:0]        mxc;

  function automatic logic idx_ok(logic [9:0] i);
    return int'(i) < MAX_VERTICES;
  endfunction

  function automatic logic [SW-1:0] sat_add(logic signed [SW-1:0] s,
                                            logic signed [FW-1:0] f);
    logic signed [XW-1:0] x;
    x = XW'(s) + XW'(f);
    if (x > SMAX) begin
      x = SMAX;
    end else if (x < SMIN) begin
      x = SMIN;
    end
    return x[SW-1:0];
  endfunction

  assign addr_a = AW'(cur.index_a);
  assign addr_b = AW'(cur.index_b);
  assign addr_c = AW'(cur.index_c);
  assign item_stall = (st != S_IDLE);

  always_comb begin
    case (corner)
      2'd0:    corner_addr = addr_a;
      2'd1:    corner_addr = addr_b;
      default: corner_addr = addr_c;
    endcase
    case (st)
      S_PA:    pos_raddr = addr_a;
      S_PB:    pos_raddr = addr_b;
      default: pos_raddr = addr_c;
    endcase
    sum_raddr = (st == S_QRD) ? addr_a : corner_addr;
    pos_we    = (st == S_LOAD) && idx_ok(cur.index_a);
    pos_wdata = {CW'(cur.pos_z), CW'(cur.pos_y), CW'(cur.pos_x)};
    for (int k = 0; k < 3; k++) begin
      e1[k] = EW'(pb[k]) - EW'(pa[k]);
      e2[k] = EW'(pc[k]) - EW'(pa[k]);
      sr[k] = sum_rdata[k*SW +: SW];
      sat_word[k*SW +: SW] = sat_add(sr[k], face[k]);
      nfull[k] = {1'b0, t[k][30:0], 14'b0} + 46'(rr >> 1);
      dext[k] = {rem[k], nlow[k][14]};
    end
    sum_we    = ((st == S_LOAD) && idx_ok(cur.index_a)) || (st == S_SWR);
    sum_waddr = (st == S_LOAD) ? addr_a : corner_addr;
    sum_wdata = (st == S_LOAD) ? '0 : sat_word;
    root_try  = res + rbit;
    rr        = (res == 64'd0) ? 32'd1 : res[31:0];
    mxc = t[0];
    if (t[1] > mxc) mxc = t[1];
    if (t[2] > mxc) mxc = t[2];
  end

  vna_ram #(.WIDTH(3*CW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(addr_a), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  vna_ram #(.WIDTH(3*SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
    .raddr(sum_raddr), .rdata(sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      result_valid <= 1'b0;
      thr          <= vna_pkg::THR_RESET;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      // a result taken while the next one is ready is replaced in S_FIN
      if (result_valid && !result_stall && (st != S_FIN)) begin
        result_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (item_valid) begin
            cur           <= item;
            pend.normal_x <= '0;
            pend.normal_y <= '0;
            pend.normal_z <= '0;
            pend.status   <= (item.operation == vna_pkg::OP_QUERY) &&
                             !idx_ok(item.index_a);
            corner        <= 2'd0;
            case (item.operation)
              vna_pkg::OP_LOAD: st <= S_LOAD;
              vna_pkg::OP_TRI: begin
                st <= (idx_ok(item.index_a) && idx_ok(item.index_b) &&
                       idx_ok(item.index_c)) ? S_PA : S_FIN;
              end
              vna_pkg::OP_QUERY: begin
                st <= idx_ok(item.index_a) ? S_QRD : S_FIN;
              end
              default: st <= S_FIN;
            endcase
          end
        end
        S_LOAD: st <= S_FIN;
        S_PA:   st <= S_PB;
        S_PB: begin
          for (int k = 0; k < 3; k++) pa[k] <= pos_rdata[k*CW +: CW];
          st <= S_PC;
        end
        S_PC: begin
          for (int k = 0; k < 3; k++) pb[k] <= pos_rdata[k*CW +: CW];
          st <= S_PD;
        end
        S_PD: begin
          for (int k = 0; k < 3; k++) pc[k] <= pos_rdata[k*CW +: CW];
          st <= S_MUL;
        end
        S_MUL: begin
          prod[0] <= PRW'(e1[1]) * PRW'(e2[2]);
          prod[1] <= PRW'(e1[2]) * PRW'(e2[1]);
          prod[2] <= PRW'(e1[2]) * PRW'(e2[0]);
          prod[3] <= PRW'(e1[0]) * PRW'(e2[2]);
          prod[4] <= PRW'(e1[0]) * PRW'(e2[1]);
          prod[5] <= PRW'(e1[1]) * PRW'(e2[0]);
          st <= S_CROSS;
        end
        S_CROSS: begin
          for (int k = 0; k < 3; k++) begin
            face[k] <= FW'(prod[2*k]) - FW'(prod[2*k+1]);
          end
          st <= S_SRD;
        end
        // read, then saturate and write back before the next corner is read
        S_SRD: st <= S_SWR;
        S_SWR: begin
          corner <= corner + 2'd1;
          st     <= (corner == 2'd2) ? S_FIN : S_SRD;
        end
        S_QRD: st <= S_QMAG;
        S_QMAG: begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= sr[k][SW-1];
            t[k]   <= sr[k][SW-1] ? (SW'(0) - sum_rdata[k*SW +: SW])
                                  : sum_rdata[k*SW +: SW];
          end
          st <= S_QSQ;
        end
        S_QSQ: begin
          mags_low <= (t[0][SW-1:20] == '0) && (t[1][SW-1:20] == '0) &&
                      (t[2][SW-1:20] == '0);
          allzero <= (t[0] == '0) && (t[1] == '0) && (t[2] == '0);
          sqs <= 42'(t[0][19:0] * t[0][19:0]) + 42'(t[1][19:0] * t[1][19:0]) +
                 42'(t[2][19:0] * t[2][19:0]);
          st <= S_QCHK;
        end
        S_QCHK: begin
          if ((mags_low && (sqs <= 42'(thr))) || allzero) begin
            pend.status <= 1'b1;
            st <= S_FIN;
          end else begin
            mx <= mxc;
            st <= S_NORM;
          end
        end
        // bring the largest magnitude into [2^30, 2^31)
        S_NORM: begin
          if (mx[SW-1:31] != '0) begin
            mx <= mx >> 1;
            for (int k = 0; k < 3; k++) t[k] <= t[k] >> 1;
          end else if (!mx[30]) begin
            mx <= mx << 1;
            for (int k = 0; k < 3; k++) t[k] <= t[k] << 1;
          end else begin
            st <= S_TSQ;
          end
        end
        S_TSQ: begin
          for (int k = 0; k < 3; k++) tsq[k] <= t[k][30:0] * t[k][30:0];
          st <= S_TSUM;
        end
        S_TSUM: begin
          rad  <= 64'(tsq[0]) + 64'(tsq[1]) + 64'(tsq[2]);
          res  <= '0;
          rbit <= 64'd1 << 62;
          rcnt <= '0;
          st   <= S_ROOT;
        end
        S_ROOT: begin
          if (rad >= root_try) begin
            rad <= rad - root_try;
            res <= (res >> 1) + rbit;
          end else begin
            res <= res >> 1;
          end
          rbit <= rbit >> 2;
          rcnt <= rcnt + 5'd1;
          if (rcnt == 5'd31) st <= S_DSET;
        end
        S_DSET: begin
          r_val <= rr;
          for (int k = 0; k < 3; k++) begin
            rem[k]  <= 32'(nfull[k][45:15]);
            nlow[k] <= nfull[k][14:0];
            q[k]    <= '0;
          end
          dcnt <= '0;
          st   <= S_DIV;
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (dext[k] >= {1'b0, r_val}) begin
              rem[k] <= 32'(dext[k] - {1'b0, r_val});
              q[k]   <= {q[k][13:0], 1'b1};
            end else begin
              rem[k] <= dext[k][31:0];
              q[k]   <= {q[k][13:0], 1'b0};
            end
            nlow[k] <= nlow[k] << 1;
          end
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd14) st <= S_OUT;
        end
        S_OUT: begin
          pend.normal_x <= neg[0] ? -16'((q[0] > vna_pkg::NORM_ONE) ? vna_pkg::NORM_ONE : q[0])
                                  : 16'((q[0] > vna_pkg::NORM_ONE) ? vna_pkg::NORM_ONE : q[0]);
          pend.normal_y <= neg[1] ? -16'((q[1] > vna_pkg::NORM_ONE) ? vna_pkg::NORM_ONE : q[1])
                                  : 16'((q[1] > vna_pkg::NORM_ONE) ? vna_pkg::NORM_ONE : q[1]);
          pend.normal_z <= neg[2] ? -16'((q[2] > vna_pkg::NORM_ONE) ? vna_pkg::NORM_ONE : q[2])
                                  : 16'((q[2] > vna_pkg::NORM_ONE) ? vna_pkg::NORM_ONE : q[2]);
          pend.status <= 1'b0;
          st <= S_FIN;
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result       <= pend;
            result_valid <= 1'b1;
            st           <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `VNA_ASSERT_IMP(a_deg_zero, result_valid && result.status, (result.normal_x == 16'sd0) && (result.normal_y == 16'sd0) && (result.normal_z == 16'sd0))
  `VNA_ASSERT_IMP(a_idle_no_write, st == S_IDLE, !sum_we && !pos_we)
  `VNA_ASSERT_IMP(a_root_range, st == S_DIV, r_val[31:30] != 2'b00)
  `VNA_ASSERT_NXT(a_fin_release, (st == S_FIN) && (!result_valid || !result_stall), result_valid && (st == S_IDLE))
endmodule
`default_nettype wire
